// File: design/line_follower_pid_drive_unit_defines.svh
// assertion helpers used by the drive unit datapath
`ifndef LINE_FOLLOWER_PID_DRIVE_UNIT_DEFINES_SVH
`define LINE_FOLLOWER_PID_DRIVE_UNIT_DEFINES_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define LFPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while in reset
`define LFPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lfpd_pkg.sv
`default_nettype none

package lfpd_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int DIV_BITS     = 40;
    localparam int CNT_W        = $clog2(DIV_BITS);

    localparam logic [2:0] REG_KP         = 3'd0;
    localparam logic [2:0] REG_KI         = 3'd1;
    localparam logic [2:0] REG_KD         = 3'd2;
    localparam logic [2:0] REG_HIGH_SPEED = 3'd3;
    localparam logic [2:0] REG_EDGE_DARK  = 3'd4;
    localparam logic [2:0] REG_HOLDOFF    = 3'd5;

    localparam logic [15:0] KP_RESET        = 16'd717;
    localparam logic [15:0] KI_RESET        = 16'd154;
    localparam logic [15:0] KD_RESET        = 16'd282;
    localparam logic [3:0]  EDGE_DARK_RESET = 4'd7;
    localparam logic [15:0] HOLDOFF_RESET   = 16'd240;

    localparam logic [6:0] RESTART_LEFT  = 7'd40;
    localparam logic [6:0] RESTART_RIGHT = 7'd45;
    localparam logic [6:0] DRIVE_MIN     = 7'd5;
    localparam logic [6:0] DRIVE_MAX     = 7'd80;
    localparam logic [6:0] LEFT_OFFSET   = 7'd43;
    localparam logic [6:0] RIGHT_OFFSET  = 7'd45;
    localparam logic [3:0] BASE_LOW      = 4'd5;
    localparam logic [3:0] BASE_HIGH     = 4'd10;

    localparam logic signed [6:0] WEIGHT [SENSOR_COUNT] =
        '{7'sd24, 7'sd16, 7'sd8, 7'sd0, 7'sd0, -7'sd8, -7'sd16, -7'sd24};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_ERR,
        ST_MUL_PID,
        ST_DIV_INIT,
        ST_DIV,
        ST_DRIVE,
        ST_FIN
    } lfpd_state_t;

    typedef struct packed {
        logic accept;
        logic mul_err;
        logic mul_pid;
        logic div_init;
        logic div_step;
        logic drive;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic short_item;
        logic div_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic signed [6:0] weighted_sum(input logic [SENSOR_COUNT-1:0] dark);
        logic signed [6:0] acc;
        acc = 7'sd0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (dark[i]) begin
                acc = acc + WEIGHT[i];
            end
        end
        return acc;
    endfunction

    // q1.8 scale picked by dark count, unity at the ends
    function automatic logic [8:0] count_scale(input logic [3:0] cnt);
        logic [8:0] m;
        case (cnt)
            4'd2:    m = 9'd128;
            4'd3:    m = 9'd85;
            4'd4:    m = 9'd64;
            4'd5:    m = 9'd84;
            4'd6:    m = 9'd128;
            default: m = 9'd256;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] clamp_drive(input logic signed [19:0] v);
        logic [6:0] r;
        if (v < $signed({13'd0, DRIVE_MIN})) begin
            r = DRIVE_MIN;
        end else if (v > $signed({13'd0, DRIVE_MAX})) begin
            r = DRIVE_MAX;
        end else begin
            r = v[6:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/lfpd_ctrl.sv
`default_nettype none

module lfpd_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire lfpd_pkg::dp_stat_t  stat,
    output lfpd_pkg::ctrl_cmd_t      cmd
);
    import lfpd_pkg::*;

    lfpd_state_t state_reg;
    lfpd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = stat.short_item ? ST_FIN : ST_MUL_ERR;
                end
            end
            ST_MUL_ERR:  state_next = ST_MUL_PID;
            ST_MUL_PID:  state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV: begin
                if (stat.div_last) begin
                    state_next = ST_DRIVE;
                end
            end
            ST_DRIVE:    state_next = ST_FIN;
            ST_FIN: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_MUL_ERR:  cmd.mul_err  = 1'b1;
            ST_MUL_PID:  cmd.mul_pid  = 1'b1;
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_DRIVE:    cmd.drive    = 1'b1;
            ST_FIN:      cmd.emit     = stat.out_free;
            default:     cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: design/lfpd_dp.sv
`default_nettype none
`include "line_follower_pid_drive_unit_defines.svh"

module lfpd_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [7:0]          s_tdata,
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [23:0]              m_tdata,
    output logic [1:0]               m_tuser,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire lfpd_pkg::ctrl_cmd_t cmd,
    output lfpd_pkg::dp_stat_t       stat
);
    import lfpd_pkg::*;

    // configuration
    logic [15:0] kp_reg, ki_reg, kd_reg, holdoff_reg;
    logic        high_speed_reg;
    logic [3:0]  edge_dark_reg;

    // run state
    logic signed [31:0] err_sum_reg;
    logic signed [7:0]  last_err_reg;
    logic [15:0]        tse_reg;
    logic [3:0]         edge_cnt_reg;

    // working registers
    logic signed [6:0]  raw_reg;
    logic [8:0]         scale_reg;
    logic signed [7:0]  err_reg;
    logic signed [15:0] p_reg;
    logic signed [15:0] d_reg;
    logic signed [48:0] ki_prod_reg;
    logic               neg_reg;
    logic [DIV_BITS-1:0] num_reg;
    logic [15:0]        rem_reg;
    logic [CNT_W-1:0]   div_cnt_reg;

    // result and output registers
    logic [6:0] res_left_reg, res_right_reg;
    logic       res_drive_reg, res_edge_reg;
    logic [3:0] res_total_reg;
    logic       m_tvalid_reg;
    logic [6:0] out_left_reg, out_right_reg;
    logic       out_drive_reg, out_edge_reg;
    logic [3:0] out_total_reg;

    logic [7:0]  dark;
    logic [7:0]  run_ends;
    logic [3:0]  dark_cnt;
    logic        one_run;
    logic [15:0] tse_inc;
    logic [3:0]  edge_inc;
    logic        is_edge;

    logic signed [16:0] err_prod, err_sh;
    logic signed [24:0] p_prod, p_sh;
    logic signed [8:0]  err_diff;
    logic signed [25:0] d_prod, d_sh;
    logic signed [48:0] ki_prod;
    logic [48:0]        prod_mag;
    logic [16:0]        rem_sh, rem_sub;
    logic               fits;
    logic [16:0]        q_sat;
    logic signed [19:0] ii, left_sum, right_sum, p_ext, d_ext;
    logic [3:0]         base;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;

    assign dark     = ~s_tdata;
    assign run_ends = dark & ~{1'b0, dark[7:1]};
    assign one_run  = (run_ends & (run_ends - 8'd1)) == 8'd0;
    assign dark_cnt = 4'($countones(dark));
    assign tse_inc  = (&tse_reg) ? tse_reg : tse_reg + 16'd1;
    assign edge_inc = (&edge_cnt_reg) ? edge_cnt_reg : edge_cnt_reg + 4'd1;
    assign is_edge  = (dark_cnt >= edge_dark_reg) && one_run && (tse_inc > holdoff_reg);

    assign err_prod = raw_reg * $signed({1'b0, scale_reg});
    assign err_sh   = err_prod[16] ? (err_prod + 17'sd255) >>> 8 : err_prod >>> 8;

    assign p_prod   = err_reg * $signed({1'b0, kp_reg});
    assign p_sh     = p_prod[24] ? (p_prod + 25'sd255) >>> 8 : p_prod >>> 8;
    assign err_diff = $signed({err_reg[7], err_reg}) - $signed({last_err_reg[7], last_err_reg});
    assign d_prod   = err_diff * $signed({1'b0, kd_reg});
    assign d_sh     = d_prod[25] ? (d_prod + 26'sd255) >>> 8 : d_prod >>> 8;
    assign ki_prod  = err_sum_reg * $signed({1'b0, ki_reg});

    assign prod_mag = ki_prod_reg[48] ? 49'(-ki_prod_reg) : 49'(ki_prod_reg);

    assign rem_sh  = {rem_reg, num_reg[DIV_BITS-1]};
    assign fits    = rem_sh >= {1'b0, tse_reg};
    assign rem_sub = fits ? rem_sh - {1'b0, tse_reg} : rem_sh;

    // beyond this magnitude the drives clamp regardless
    assign q_sat  = (|num_reg[DIV_BITS-1:17]) ? '1 : num_reg[16:0];
    assign ii     = neg_reg ? -$signed({3'b0, q_sat}) : $signed({3'b0, q_sat});
    assign base   = high_speed_reg ? BASE_HIGH : BASE_LOW;
    assign p_ext  = $signed({{4{p_reg[15]}}, p_reg});
    assign d_ext  = $signed({{4{d_reg[15]}}, d_reg});
    assign left_sum  = $signed({13'd0, LEFT_OFFSET}) + $signed({16'd0, base})
                     + p_ext - ii + d_ext;
    assign right_sum = $signed({13'd0, RIGHT_OFFSET}) + $signed({16'd0, base})
                     - p_ext + ii - d_ext;

    assign sum_wide = $signed({err_sum_reg[31], err_sum_reg})
                    + $signed({{25{err_reg[7]}}, err_reg});
    always_comb begin
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sum_sat = sum_wide[31:0];
        end
    end

    assign stat.short_item = s_tuser || is_edge;
    assign stat.div_last   = div_cnt_reg == CNT_W'(DIV_BITS - 1);
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    // configuration, control and run state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg         <= KP_RESET;
            ki_reg         <= KI_RESET;
            kd_reg         <= KD_RESET;
            high_speed_reg <= 1'b0;
            edge_dark_reg  <= EDGE_DARK_RESET;
            holdoff_reg    <= HOLDOFF_RESET;
            err_sum_reg    <= '0;
            last_err_reg   <= '0;
            tse_reg        <= '0;
            edge_cnt_reg   <= '0;
            div_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_KP:         kp_reg         <= cfg_data;
                    REG_KI:         ki_reg         <= cfg_data;
                    REG_KD:         kd_reg         <= cfg_data;
                    REG_HIGH_SPEED: high_speed_reg <= cfg_data[0];
                    REG_EDGE_DARK:  edge_dark_reg  <= cfg_data[3:0];
                    REG_HOLDOFF:    holdoff_reg    <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.accept) begin
                if (s_tuser) begin
                    err_sum_reg  <= '0;
                    last_err_reg <= '0;
                    tse_reg      <= '0;
                    edge_cnt_reg <= '0;
                end else if (is_edge) begin
                    err_sum_reg  <= '0;
                    tse_reg      <= '0;
                    edge_cnt_reg <= edge_inc;
                end else begin
                    tse_reg <= tse_inc;
                end
            end
            if (cmd.div_init) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + CNT_W'(1);
            end
            if (cmd.drive) begin
                err_sum_reg  <= sum_sat;
                last_err_reg <= err_reg;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            raw_reg   <= weighted_sum(dark);
            scale_reg <= count_scale(dark_cnt);
            if (s_tuser) begin
                res_left_reg  <= RESTART_LEFT;
                res_right_reg <= RESTART_RIGHT;
                res_drive_reg <= 1'b1;
                res_edge_reg  <= 1'b0;
                res_total_reg <= '0;
            end else begin
                res_left_reg  <= '0;
                res_right_reg <= '0;
                res_drive_reg <= 1'b0;
                res_edge_reg  <= 1'b1;
                res_total_reg <= edge_inc;
            end
        end
        if (cmd.mul_err) begin
            err_reg <= err_sh[7:0];
        end
        if (cmd.mul_pid) begin
            p_reg       <= p_sh[15:0];
            d_reg       <= d_sh[15:0];
            ki_prod_reg <= ki_prod;
        end
        if (cmd.div_init) begin
            neg_reg <= ki_prod_reg[48];
            num_reg <= prod_mag[47:8];
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_sub[15:0];
            num_reg <= {num_reg[DIV_BITS-2:0], fits};
        end
        if (cmd.drive) begin
            res_left_reg  <= clamp_drive(left_sum);
            res_right_reg <= clamp_drive(right_sum);
            res_drive_reg <= 1'b1;
            res_edge_reg  <= 1'b0;
            res_total_reg <= edge_cnt_reg;
        end
        if (cmd.emit) begin
            out_left_reg  <= res_left_reg;
            out_right_reg <= res_right_reg;
            out_drive_reg <= res_drive_reg;
            out_edge_reg  <= res_edge_reg;
            out_total_reg <= res_total_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {6'd0, out_total_reg, out_right_reg, out_left_reg};
    assign m_tuser   = {out_edge_reg, out_drive_reg};

    `LFPD_ASSERT_NEXT(a_restart_clears, cmd.accept && s_tuser, (edge_cnt_reg == 4'd0) && (err_sum_reg == 32'sd0) && (tse_reg == 16'd0), "restart left run state behind")
    `LFPD_ASSERT_SAME(a_div_nonzero, cmd.div_step, tse_reg != 16'd0, "integral divisor is zero")
    `LFPD_ASSERT_SAME(a_drive_range, m_tvalid_reg && out_drive_reg, (out_left_reg >= DRIVE_MIN) && (out_left_reg <= DRIVE_MAX) && (out_right_reg >= DRIVE_MIN) && (out_right_reg <= DRIVE_MAX), "drive beat out of range")
    `LFPD_ASSERT_SAME(a_edge_blank, m_tvalid_reg && out_edge_reg, !out_drive_reg && (out_left_reg == 7'd0) && (out_right_reg == 7'd0), "edge beat carries drives")

endmodule

`default_nettype wire

// File: design/line_follower_pid_drive_unit.sv
// Line follower PID drive unit. Each input beat carries the eight sensor bits
// (0 = dark) and a restart flag; each produces exactly one output beat with the
// left and right drives, drive/edge flags and the edge count. A normal tick
// runs the error multiply, the PID multiply, the divide set-up, the divide and
// the drive step in order, then waits for the output register to be free; the
// input is ready again once the result is placed there. The restoring divide
// of the integral term by the ticks since the last edge runs one quotient bit
// per cycle on a shared subtractor. Restart and cross-line edge ticks skip the
// arithmetic and go straight to the output register. Results sit in an output
// register, so the unit holds one item in flight while the previous result
// waits to be taken. Configuration writes (index 0..5, others ignored) are
// always ready and are meant to happen only while the unit is idle.
`default_nettype none

module line_follower_pid_drive_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // sensor_bits
    input  wire logic        s_tuser,   // restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // left_drive, right_drive, edge_total, zero pad
    output logic [1:0]       m_tuser,   // drive_valid, edge_seen
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import lfpd_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    lfpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfpd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// File: sim/line_follower_pid_drive_unit_tb.sv
`default_nettype none

module line_follower_pid_drive_unit_tb;
    import lfpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam longint SENSOR_WEIGHT [8] = '{24, 16, 8, 0, 0, -8, -16, -24};
    localparam longint DARK_SCALE [9]    = '{256, 256, 128, 85, 64, 84, 128, 256, 256};

    typedef struct packed {
        logic [6:0] left_drive;
        logic [6:0] right_drive;
        logic       drive_valid;
        logic       edge_seen;
        logic [3:0] edge_total;
    } drive_beat_t;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  idx;
        logic [15:0] val;
        logic        restart;
        logic [7:0]  bits;
        logic        typed;
        drive_beat_t want;
    } stim_row_t;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic        fast;
        logic [3:0]  dark_min;
        logic [15:0] holdoff;
        int          gap_pct;
        int          stall_pct;
        int          n_ticks;
        logic        press;
    } phase_t;

    localparam drive_beat_t NO_WANT      = '0;
    localparam drive_beat_t WANT_RESTART = '{7'd40, 7'd45, 1'b1, 1'b0, 4'd0};

    localparam int N_ROWS = 28;
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hFF, 1'b1, '{7'd48, 7'd50, 1'b1, 1'b0, 4'd0}},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'h00, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hFE, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'h7F, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hFC, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hF8, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hF0, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hE0, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hC0, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'h80, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hA5, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b1, 8'h00, 1'b1, WANT_RESTART},
        '{1'b1, REG_HOLDOFF, 16'd0, 1'b0, 8'h00, 1'b0, NO_WANT},
        '{1'b1, REG_EDGE_DARK, 16'd1, 1'b0, 8'h00, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hFE, 1'b1, '{7'd0, 7'd0, 1'b0, 1'b1, 4'd1}},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hAA, 1'b0, NO_WANT},
        '{1'b1, REG_EDGE_DARK, 16'd0, 1'b0, 8'h00, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hFF, 1'b1, '{7'd0, 7'd0, 1'b0, 1'b1, 4'd2}},
        '{1'b1, REG_EDGE_DARK, 16'd15, 1'b0, 8'h00, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'h00, 1'b0, NO_WANT},
        '{1'b1, REG_SPARE_LO, 16'hFFFF, 1'b0, 8'h00, 1'b0, NO_WANT},
        '{1'b1, REG_SPARE_HI, 16'h0000, 1'b0, 8'h00, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'h0F, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b1, 8'hFF, 1'b1, WANT_RESTART},
        '{1'b1, REG_HIGH_SPEED, 16'd1, 1'b0, 8'h00, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'h3C, 1'b0, NO_WANT},
        '{1'b1, REG_KP, 16'hFFFF, 1'b0, 8'h00, 1'b0, NO_WANT},
        '{1'b0, REG_KP, 16'd0, 1'b0, 8'hFE, 1'b0, NO_WANT}
    };

    localparam int N_PHASES = 8;
    localparam phase_t PHASES [N_PHASES] = '{
        '{16'd717, 16'd154, 16'd282, 1'b0, 4'd7, 16'd240, 0, 0, 100, 1'b0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 4'd8, 16'd0, 88, 0, 100, 1'b0},
        '{16'd0, 16'd0, 16'd0, 1'b0, 4'd1, 16'd3, 0, 88, 100, 1'b0},
        '{16'd1024, 16'd512, 16'd300, 1'b1, 4'd5, 16'd10, 15, 15, 230, 1'b0},
        '{16'd717, 16'd154, 16'd282, 1'b0, 4'd0, 16'd1, 0, 0, 100, 1'b0},
        '{16'd300, 16'd40000, 16'd2000, 1'b1, 4'd15, 16'hFFFF, 15, 15, 100, 1'b0},
        '{16'd5000, 16'd1000, 16'd800, 1'b0, 4'd3, 16'd20, 0, 0, 100, 1'b1},
        '{16'd128, 16'd2048, 16'd4096, 1'b1, 4'd6, 16'd2, 88, 0, 100, 1'b0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    line_follower_pid_drive_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller copy: gains, thresholds and loop state
    longint gain_p = 717;
    longint gain_i = 154;
    longint gain_d = 282;
    longint holdoff = 240;
    longint dark_min = 7;
    bit     fast = 1'b0;
    longint err_sum = 0;
    longint prev_err = 0;
    longint since_edge = 0;
    int     edges = 0;

    drive_beat_t drive_beats_due [$];

    int  gap_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 1'b0;
    int  mismatches = 0;
    int  ticks_sent = 0;
    int  restarts_sent = 0;
    int  edges_seen = 0;
    int  clamped_seen = 0;
    int  cycle_count = 0;

    function automatic bit single_run(input logic [7:0] dark);
        int unsigned d;
        d = dark;
        if (d == 0) return 1'b1;
        while ((d & 1) == 0) d = d >> 1;
        return ((d + 1) & d) == 0;
    endfunction

    function automatic logic [6:0] limit_drive(input longint v);
        if (v < 5) return 7'd5;
        if (v > 80) return 7'd80;
        return v[6:0];
    endfunction

    function automatic drive_beat_t next_drive(input logic restart, input logic [7:0] bits);
        drive_beat_t r;
        logic [7:0]  dark;
        int          n_dark;
        longint      raw, err, p, ig, dg, base, acc;
        r = '0;
        dark = ~bits;
        if (restart) begin
            err_sum = 0;
            prev_err = 0;
            since_edge = 0;
            edges = 0;
            return WANT_RESTART;
        end
        if (since_edge < 65535) since_edge++;
        n_dark = $countones(dark);
        raw = 0;
        for (int k = 0; k < 8; k++) begin
            if (dark[k]) raw += SENSOR_WEIGHT[k];
        end
        if (n_dark >= dark_min && single_run(dark) && since_edge > holdoff) begin
            since_edge = 0;
            err_sum = 0;
            if (edges < 15) edges++;
            r.edge_seen = 1'b1;
            r.edge_total = edges[3:0];
            return r;
        end
        err = raw * DARK_SCALE[n_dark] / 256;
        p = err * gain_p / 256;
        ig = err_sum * gain_i / (256 * since_edge);
        dg = (err - prev_err) * gain_d / 256;
        base = fast ? 10 : 5;
        r.left_drive = limit_drive(43 + base + p - ig + dg);
        r.right_drive = limit_drive(45 + base - p + ig - dg);
        r.drive_valid = 1'b1;
        r.edge_total = edges[3:0];
        acc = err_sum + err;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        err_sum = acc;
        prev_err = err;
        return r;
    endfunction

    // mostly contiguous dark runs so the edge detector gets exercised
    function automatic logic [7:0] random_sensors();
        int unsigned len, lo;
        logic [15:0] run;
        if ($urandom_range(99) < 70) begin
            len = $urandom_range(8);
            lo = $urandom_range(8 - len);
            run = ((16'd1 << len) - 16'd1) << lo;
            return ~run[7:0];
        end
        return 8'($urandom);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_KP:         gain_p = val;
            REG_KI:         gain_i = val;
            REG_KD:         gain_d = val;
            REG_HIGH_SPEED: fast = val[0];
            REG_EDGE_DARK:  dark_min = val[3:0];
            REG_HOLDOFF:    holdoff = val;
            default: ;
        endcase
    endtask

    task automatic offer_tick(input logic restart, input logic [7:0] bits,
                              input logic typed, input drive_beat_t want);
        drive_beat_t r;
        s_tvalid <= 1'b1;
        s_tdata <= bits;
        s_tuser <= restart;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = next_drive(restart, bits);
        drive_beats_due.push_back(typed ? want : r);
        ticks_sent++;
        if (restart) restarts_sent++;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (drive_beats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        drive_beat_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.left_drive = m_tdata[6:0];
            got.right_drive = m_tdata[13:7];
            got.edge_total = m_tdata[17:14];
            got.drive_valid = m_tuser[0];
            got.edge_seen = m_tuser[1];
            if (got.edge_seen) edges_seen++;
            if (got.drive_valid && (got.left_drive == 7'd80 || got.left_drive == 7'd5))
                clamped_seen++;
            if (drive_beats_due.size() == 0) begin
                $error("drive beat with nothing pending");
                mismatches++;
            end else begin
                want = drive_beats_due.pop_front();
                if (got.left_drive != want.left_drive) begin
                    $error("left_drive: expected %0d, got %0d", want.left_drive, got.left_drive);
                    mismatches++;
                end
                if (got.right_drive != want.right_drive) begin
                    $error("right_drive: expected %0d, got %0d",
                           want.right_drive, got.right_drive);
                    mismatches++;
                end
                if (got.drive_valid != want.drive_valid) begin
                    $error("drive_valid: expected %0d, got %0d",
                           want.drive_valid, got.drive_valid);
                    mismatches++;
                end
                if (got.edge_seen != want.edge_seen) begin
                    $error("edge_seen: expected %0d, got %0d", want.edge_seen, got.edge_seen);
                    mismatches++;
                end
                if (got.edge_total != want.edge_total) begin
                    $error("edge_total: expected %0d, got %0d",
                           want.edge_total, got.edge_total);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats pending", cycle_count,
                 drive_beats_due.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'hFF;
        s_tuser <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_KP;
        cfg_data <= 16'd0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            if (DIRECTED[i].is_cfg) begin
                settle();
                write_reg(DIRECTED[i].idx, DIRECTED[i].val);
                cfg_valid <= 1'b0;
            end else begin
                offer_tick(DIRECTED[i].restart, DIRECTED[i].bits,
                           DIRECTED[i].typed, DIRECTED[i].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            gap_pct = 0;
            stall_pct = 0;
            write_reg(REG_KP, PHASES[ph].kp);
            write_reg(REG_KI, PHASES[ph].ki);
            write_reg(REG_KD, PHASES[ph].kd);
            write_reg(REG_HIGH_SPEED, {15'd0, PHASES[ph].fast});
            write_reg(REG_EDGE_DARK, {12'd0, PHASES[ph].dark_min});
            write_reg(REG_HOLDOFF, PHASES[ph].holdoff);
            cfg_valid <= 1'b0;
            gap_pct = PHASES[ph].gap_pct;
            stall_pct = PHASES[ph].stall_pct;
            for (int n = 0; n < PHASES[ph].n_ticks; n++) begin
                // long receiver stall so the unit backs up into its input
                if (PHASES[ph].press && n == 10) hold_req = 1'b1;
                if ($urandom_range(99) < 3)
                    offer_tick(1'b1, 8'($urandom), 1'b0, NO_WANT);
                else
                    offer_tick(1'b0, random_sensors(), 1'b0, NO_WANT);
            end
        end

        s_tvalid <= 1'b0;
        while (drive_beats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d sensor beats (%0d restarts) over %0d gain/threshold settings",
                 ticks_sent, restarts_sent, N_PHASES + 1);
        $display("%0d cross-line edges and %0d clamped left drives observed",
                 edges_seen, clamped_seen);
        if (mismatches == 0 && drive_beats_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+design
design/lfpd_pkg.sv
design/lfpd_ctrl.sv
design/lfpd_dp.sv
design/line_follower_pid_drive_unit.sv
sim/line_follower_pid_drive_unit_tb.sv
